// ===== rtl/kfls_pkg.sv =====
package kfls_pkg;

  localparam int TIME_W   = 24;
  localparam int VAL_W    = 32;
  localparam int FRAC_W   = 16;
  localparam int DIFF_W   = VAL_W + 1;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int DCNT_W   = $clog2(FRAC_W);
  localparam int COUNT_W  = 6;
  localparam int SLOT_W   = 5;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_INTERP = 2'd0,
    ST_HOLD   = 2'd1,
    ST_ZERO   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_t;

  typedef enum logic {
    SRC_CUR  = 1'b0,
    SRC_PREV = 1'b1
  } src_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_PREV,
    S_CMP,
    S_CHECK,
    S_DIV,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3
  } state_t;

  typedef struct packed {
    logic [TIME_W-1:0] tm;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } key_t;

  typedef struct packed {
    logic    key_write;
    logic    load_query;
    logic    idx_clear;
    logic    idx_inc;
    logic    capture_prev;
    logic    capture_hi;
    logic    div_init;
    logic    div_step;
    logic    mul_en;
    comp_t   mul_sel;
    logic    add_en;
    comp_t   add_sel;
    logic    emit_key;
    src_t    emit_src;
    logic    finish;
    status_t emit_status;
  } cmd_t;

  typedef struct packed {
    logic single;
    logic cur_last;
    logic q_lt_cur;
    logic zero_len;
    logic q_lt_lo;
    logic div_last;
  } dp_stat_t;

endpackage

// ===== rtl/keyframe_linear_sampler.sv =====
// Keyframe sampler over a table of up to MAX_KEYS keys. A load word (kind 0)
// is written to the table while busy stays low, and no result follows. A sample
// word (kind 1) holds busy high while the key table is scanned at
// one key a cycle, a 16-step radix-2 divider forms the factor and one shared
// multiplier works through the three components. The result appears on
// out_x, out_y, out_z and status for exactly one cycle with done high, as busy
// falls; it cannot be held off, so it must be captured then. key_count is
// written through the cfg channel while the block is idle.
module keyframe_linear_sampler #(
  parameter int MAX_KEYS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [kfls_pkg::SLOT_W-1:0]       key_slot,
  input  logic [kfls_pkg::TIME_W-1:0]       key_time,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_x,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_y,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_z,
  input  logic [kfls_pkg::TIME_W-1:0]       query_time,
  output logic                              done,
  output logic signed [kfls_pkg::VAL_W-1:0] out_x,
  output logic signed [kfls_pkg::VAL_W-1:0] out_y,
  output logic signed [kfls_pkg::VAL_W-1:0] out_z,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kfls_pkg::COUNT_W-1:0]      cfg_data
);
  import kfls_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  assign cfg_ready = ~busy;

  kfls_control u_control (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  kfls_datapath #(
    .MAX_KEYS (MAX_KEYS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .key_slot   (key_slot),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .query_time (query_time),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .status     (status),
    .done       (done)
  );

  // A result only ever follows a sample word that kept the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a sample in progress");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_SAMPLE) |=> busy)
    else $error("sample word accepted but block not busy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == KIND_LOAD) |=> (!done && !busy))
    else $error("load word produced a result or stalled the block");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_INTERP || status == ST_HOLD || status == ST_ZERO))
    else $error("result carries an unused status code");

endmodule

// ===== rtl/kfls_datapath.sv =====
module kfls_datapath #(
  parameter int MAX_KEYS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kfls_pkg::cmd_t                    cmd,
  output kfls_pkg::dp_stat_t                stat,
  input  logic                              cfg_we,
  input  logic [kfls_pkg::COUNT_W-1:0]      cfg_data,
  input  logic [kfls_pkg::SLOT_W-1:0]       key_slot,
  input  logic [kfls_pkg::TIME_W-1:0]       key_time,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_x,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_y,
  input  logic signed [kfls_pkg::VAL_W-1:0] key_z,
  input  logic [kfls_pkg::TIME_W-1:0]       query_time,
  output logic signed [kfls_pkg::VAL_W-1:0] out_x,
  output logic signed [kfls_pkg::VAL_W-1:0] out_y,
  output logic signed [kfls_pkg::VAL_W-1:0] out_z,
  output logic [1:0]                        status,
  output logic                              done
);
  import kfls_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = (AW > COUNT_W) ? AW : COUNT_W;

  key_t                     mem [MAX_KEYS];
  key_t                     rd_word;
  key_t                     prev;
  key_t                     hi;
  logic [CW-1:0]            scan_idx;
  logic [CW-1:0]            rd_idx;
  logic [CW-1:0]            last_idx;
  logic [COUNT_W-1:0]       key_count;
  logic [TIME_W-1:0]        q;
  logic [TIME_W-1:0]        rem;
  logic [TIME_W-1:0]        den;
  logic [FRAC_W-1:0]        quo;
  logic [DCNT_W-1:0]        div_cnt;
  logic [TIME_W:0]          shifted;
  logic                     ge;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic signed [DIFF_W-1:0] d_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  s_sel;
  logic [VAL_W-1:0]         sum;
  status_t                  st_reg;
  key_t                     emit_word;

  // A zero or oversized key count is clamped to the table.
  always_comb begin
    if (key_count == '0) begin
      last_idx = '0;
    end else if (int'(key_count) > MAX_KEYS) begin
      last_idx = CW'(MAX_KEYS - 1);
    end else begin
      last_idx = CW'(key_count - COUNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= COUNT_W'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  // Key table: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.key_write && (int'(key_slot) < MAX_KEYS)) begin
      mem[AW'(key_slot)] <= '{tm: key_time, x: key_x, y: key_y, z: key_z};
    end
    rd_word <= mem[scan_idx[AW-1:0]];
  end

  // The read address runs one ahead of the word being compared, so rd_idx
  // tells which key sits in rd_word.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
    end else if (cmd.idx_clear) begin
      scan_idx <= '0;
    end else if (cmd.idx_inc && (scan_idx != last_idx)) begin
      scan_idx <= scan_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (cmd.load_query) begin
      q <= query_time;
    end
    if (cmd.capture_prev) begin
      prev <= rd_word;
    end
    if (cmd.capture_hi) begin
      hi <= rd_word;
    end
  end

  assign stat.single   = (last_idx == '0);
  assign stat.cur_last = (rd_idx == last_idx);
  assign stat.q_lt_cur = (q < rd_word.tm);
  assign stat.zero_len = (hi.tm == prev.tm);
  assign stat.q_lt_lo  = (q < prev.tm);
  assign stat.div_last = (div_cnt == DCNT_W'(FRAC_W - 1));

  // Restoring divider, one quotient bit a cycle. The partial remainder starts
  // below the divisor, so the quotient fits in the fraction width.
  assign shifted = {rem, 1'b0};
  assign ge      = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= q - prev.tm;
      den <= hi.tm - prev.tm;
      quo <= '0;
      dx  <= DIFF_W'(signed'(hi.x)) - DIFF_W'(signed'(prev.x));
      dy  <= DIFF_W'(signed'(hi.y)) - DIFF_W'(signed'(prev.y));
      dz  <= DIFF_W'(signed'(hi.z)) - DIFF_W'(signed'(prev.z));
    end else if (cmd.div_step) begin
      rem <= ge ? TIME_W'(shifted - {1'b0, den}) : shifted[TIME_W-1:0];
      quo <= {quo[FRAC_W-2:0], ge};
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      COMP_X:  d_sel = dx;
      COMP_Y:  d_sel = dy;
      COMP_Z:  d_sel = dz;
      default: d_sel = dx;
    endcase
    case (cmd.add_sel)
      COMP_X:  s_sel = signed'(prev.x);
      COMP_Y:  s_sel = signed'(prev.y);
      COMP_Z:  s_sel = signed'(prev.z);
      default: s_sel = signed'(prev.x);
    endcase
  end

  // The arithmetic shift of the product floors the scaled difference.
  assign sum = VAL_W'(s_sel) + prod[FRAC_W +: VAL_W];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= PROD_W'(signed'({1'b0, quo})) * PROD_W'(d_sel);
    end
  end

  assign emit_word = (cmd.emit_src == SRC_PREV) ? prev : rd_word;

  always_ff @(posedge clk) begin
    if (cmd.emit_key) begin
      out_x <= emit_word.x;
      out_y <= emit_word.y;
      out_z <= emit_word.z;
    end else if (cmd.add_en) begin
      case (cmd.add_sel)
        COMP_X:  out_x <= sum;
        COMP_Y:  out_y <= sum;
        COMP_Z:  out_z <= sum;
        default: out_x <= sum;
      endcase
    end
    if (cmd.emit_key || cmd.finish) begin
      st_reg <= cmd.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_key | cmd.finish;
    end
  end

  assign status = st_reg;

endmodule

// ===== rtl/kfls_control.sv =====
module kfls_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               kind,
  input  kfls_pkg::dp_stat_t stat,
  output kfls_pkg::cmd_t     cmd,
  output logic               busy
);
  import kfls_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          if (kind == KIND_LOAD) begin
            cmd.key_write = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            cmd.idx_clear  = 1'b1;
            state_next     = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.idx_inc = 1'b1;
        state_next  = S_PREV;
      end
      S_PREV: begin
        cmd.capture_prev = 1'b1;
        if (stat.single) begin
          cmd.emit_key    = 1'b1;
          cmd.emit_src    = SRC_CUR;
          cmd.emit_status = ST_INTERP;
          state_next      = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.q_lt_cur) begin
          cmd.capture_hi = 1'b1;
          state_next     = S_CHECK;
        end else if (stat.cur_last) begin
          cmd.emit_key    = 1'b1;
          cmd.emit_src    = SRC_CUR;
          cmd.emit_status = ST_HOLD;
          state_next      = S_IDLE;
        end else begin
          cmd.capture_prev = 1'b1;
          cmd.idx_inc      = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.zero_len) begin
          cmd.emit_key    = 1'b1;
          cmd.emit_src    = SRC_PREV;
          cmd.emit_status = ST_ZERO;
          state_next      = S_IDLE;
        end else if (stat.q_lt_lo) begin
          cmd.emit_key    = 1'b1;
          cmd.emit_src    = SRC_PREV;
          cmd.emit_status = ST_INTERP;
          state_next      = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = COMP_X;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = COMP_X;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = COMP_Y;
        state_next  = S_MUL2;
      end
      S_MUL2: begin
        cmd.add_en  = 1'b1;
        cmd.add_sel = COMP_Y;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = COMP_Z;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.add_en      = 1'b1;
        cmd.add_sel     = COMP_Z;
        cmd.finish      = 1'b1;
        cmd.emit_status = ST_INTERP;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/sv/keyframe_linear_sampler_tb.sv =====
`timescale 1ns / 100ps

module keyframe_linear_sampler_tb;
  import kfls_pkg::*;

  localparam int TRACK_KEYS  = 32;
  localparam int WORD_TARGET = 1350;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE      = 80;

  typedef struct {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    status_t          st;
  } track_point_t;

  // Shadow copy of the key table and key_count, with the samples still owed.
  class key_track_checker;
    logic [COUNT_W-1:0]       key_count;
    logic [TIME_W-1:0]        key_times [TRACK_KEYS];
    logic signed [VAL_W-1:0]  key_xs [TRACK_KEYS];
    logic signed [VAL_W-1:0]  key_ys [TRACK_KEYS];
    logic signed [VAL_W-1:0]  key_zs [TRACK_KEYS];
    track_point_t             owed_points [$];
    int                       failures;

    function new();
      key_count = COUNT_W'(1);
      failures  = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] v);
      key_count = v;
    endfunction

    function int pending();
      return owed_points.size();
    endfunction

    function int used_keys();
      int n;
      n = int'(key_count);
      if (n < 1) n = 1;
      if (n > TRACK_KEYS) n = TRACK_KEYS;
      return n;
    endfunction

    function track_point_t key_point(int i, status_t st);
      track_point_t p;
      p.x  = key_xs[i];
      p.y  = key_ys[i];
      p.z  = key_zs[i];
      p.st = st;
      return p;
    endfunction

    // start + floor(factor * (end - start) / 2^16); the shift is arithmetic, hence a floor.
    function logic [VAL_W-1:0] blend(logic signed [VAL_W-1:0] s, logic signed [VAL_W-1:0] e,
                                     longint factor);
      longint sl;
      longint d;
      longint r;
      sl = s;
      d  = longint'(e) - sl;
      r  = sl + ((factor * d) >>> FRAC_W);
      return r[VAL_W-1:0];
    endfunction

    function track_point_t sample_track(logic [TIME_W-1:0] q);
      int n;
      int lo;
      bit found;
      longint tlo;
      longint thi;
      longint factor;
      track_point_t p;
      n = used_keys();
      found = 0;
      lo = 0;
      if (n == 1) return key_point(0, ST_INTERP);
      for (int i = 0; i + 1 < n; i++) begin
        if (q < key_times[i+1]) begin
          lo = i;
          found = 1;
          break;
        end
      end
      if (!found) return key_point(n - 1, ST_HOLD);
      tlo = key_times[lo];
      thi = key_times[lo+1];
      if (thi == tlo) return key_point(lo, ST_ZERO);
      if (longint'(q) < tlo) return key_point(lo, ST_INTERP);
      factor = ((longint'(q) - tlo) << FRAC_W) / (thi - tlo);
      p.x  = blend(key_xs[lo], key_xs[lo+1], factor);
      p.y  = blend(key_ys[lo], key_ys[lo+1], factor);
      p.z  = blend(key_zs[lo], key_zs[lo+1], factor);
      p.st = ST_INTERP;
      return p;
    endfunction

    function void note_word(logic k, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] t,
                            logic [VAL_W-1:0] x, logic [VAL_W-1:0] y, logic [VAL_W-1:0] z,
                            logic [TIME_W-1:0] q);
      if (k == KIND_LOAD) begin
        key_times[slot] = t;
        key_xs[slot]    = x;
        key_ys[slot]    = y;
        key_zs[slot]    = z;
      end else begin
        owed_points = {owed_points, sample_track(q)};
      end
    endfunction

    function void compare_field(string name, logic [VAL_W-1:0] e, logic [VAL_W-1:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h, got %h", $time, name, e, a);
        failures++;
      end
    endfunction

    function void check_point(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y, logic [VAL_W-1:0] z,
                              logic [1:0] st);
      track_point_t p;
      if (owed_points.size() == 0) begin
        $display("%0t: unrequested result, expected none, got %h %h %h status %0d",
                 $time, x, y, z, st);
        failures++;
        return;
      end
      p = owed_points.pop_front();
      compare_field("out_x", p.x, x);
      compare_field("out_y", p.y, y);
      compare_field("out_z", p.z, z);
      compare_field("status", VAL_W'(p.st), VAL_W'(st));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     kind = KIND_LOAD;
  logic [SLOT_W-1:0]        key_slot = '0;
  logic [TIME_W-1:0]        key_time = '0;
  logic signed [VAL_W-1:0]  key_x = '0;
  logic signed [VAL_W-1:0]  key_y = '0;
  logic signed [VAL_W-1:0]  key_z = '0;
  logic [TIME_W-1:0]        query_time = '0;
  logic                     done;
  logic signed [VAL_W-1:0]  out_x;
  logic signed [VAL_W-1:0]  out_y;
  logic signed [VAL_W-1:0]  out_z;
  logic [1:0]               status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [COUNT_W-1:0]       cfg_data = '0;

  key_track_checker chk = new();
  int words_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;

  keyframe_linear_sampler #(.MAX_KEYS(TRACK_KEYS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .key_slot   (key_slot),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .query_time (query_time),
    .done       (done),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done) chk.check_point(out_x, out_y, out_z, status);
  end

  task automatic send_word(logic k, logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] t,
                           logic [VAL_W-1:0] x, logic [VAL_W-1:0] y, logic [VAL_W-1:0] z,
                           logic [TIME_W-1:0] q);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    burst_left--;
    start      <= 1'b1;
    kind       <= k;
    key_slot   <= slot;
    key_time   <= t;
    key_x      <= x;
    key_y      <= y;
    key_z      <= z;
    query_time <= q;
    do @(posedge clk); while (busy);
    chk.note_word(k, slot, t, x, y, z, q);
    words_sent++;
  endtask

  task automatic put_key(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] t,
                         logic [VAL_W-1:0] x, logic [VAL_W-1:0] y, logic [VAL_W-1:0] z);
    send_word(KIND_LOAD, slot, t, x, y, z, TIME_W'($urandom));
  endtask

  task automatic ask(logic [TIME_W-1:0] q);
    send_word(KIND_SAMPLE, SLOT_W'($urandom), TIME_W'($urandom), $urandom, $urandom, $urandom,
              q);
  endtask

  // key_count may only change while the block is idle.
  task automatic set_key_count(logic [COUNT_W-1:0] v);
    start <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    chk.set_count(v);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // Loads keys 0..n-1 as a mostly ascending track, with the odd repeated or
  // backward time to bring out zero-length and out-of-order segments.
  task automatic build_track(int n);
    int t;
    int r;
    t = $urandom_range(0, 'h400);
    for (int i = 0; i < n; i++) begin
      put_key(SLOT_W'(i), TIME_W'(t), rand_value(), rand_value(), rand_value());
      r = $urandom_range(0, 99);
      if (r < 8) t = t;
      else if (r < 12) t = t - $urandom_range(0, 'h100);
      else if (r < 20) t = t + $urandom_range(0, 'hFFFFF);
      else t = t + $urandom_range(1, 'h800);
      if (t < 0) t = 0;
      if (t > 'hFF_FFFF) t = 'hFF_FFFF;
    end
  endtask

  function automatic logic [TIME_W-1:0] pick_query(int n);
    int r;
    int i;
    logic [TIME_W-1:0] first_t;
    logic [TIME_W-1:0] last_t;
    r = $urandom_range(0, 99);
    i = $urandom_range(0, n - 1);
    first_t = chk.key_times[0];
    last_t  = chk.key_times[n-1];
    if (r < 55) return TIME_W'($urandom_range(first_t, last_t));
    if (r < 70) return chk.key_times[i] + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
    if (r < 78) return TIME_W'($urandom_range(last_t, 'hFF_FFFF));
    if (r < 84) return '0;
    return TIME_W'($urandom);
  endfunction

  initial begin
    int phase;
    int cnt;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-key track at both ends of the time range.
    put_key(0, 24'h10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    ask(24'h0);
    ask(24'hFF_FFFF);
    // Full-swing values, a repeated time at the front and a last key at the top time.
    put_key(1, 24'h10, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    put_key(2, 24'h200, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
    put_key(3, 24'hFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000);
    set_key_count(4);
    ask(24'h0);
    ask(24'h10);
    ask(24'h100);
    ask(24'h1FF);
    ask(24'h200);
    ask(24'hFF_FFFE);
    ask(24'hFF_FFFF);
    // Query ahead of the first key, then keys out of order.
    set_key_count(3);
    put_key(1, 24'h80, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
    ask(24'h4);
    ask(24'h50);
    put_key(2, 24'h40, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    ask(24'h90);
    ask(24'h30);

    // From here on every slot has been written, so any key_count is safe to sample.
    build_track(TRACK_KEYS);
    phase = 0;
    while (words_sent < WORD_TARGET) begin
      case (phase)
        0:       cnt = 32;
        1:       cnt = 2;
        2:       cnt = 0;
        3:       cnt = 63;
        4:       cnt = 1;
        5:       cnt = 33;
        default: cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
      endcase
      set_key_count(COUNT_W'(cnt));
      n = chk.used_keys();
      if (phase < 6 || $urandom_range(0, 9) < 6) build_track(n);
      repeat ($urandom_range(30, 90)) begin
        if ($urandom_range(0, 99) < 12)
          put_key(SLOT_W'($urandom), TIME_W'($urandom), rand_value(), rand_value(),
                  rand_value());
        else
          ask(pick_query(n));
      end
      phase++;
    end

    start <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (chk.failures == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kfls_pkg.sv
rtl/kfls_datapath.sv
rtl/kfls_control.sv
rtl/keyframe_linear_sampler.sv
tb/sv/keyframe_linear_sampler_tb.sv
